// ===== design/segment_intersection_test_core_macros.svh =====
// Assertion macros for the segment intersection test core.
// Included by the modules that carry concurrent checks; needs clock and reset in scope.
`ifndef SEGMENT_INTERSECTION_TEST_CORE_MACROS_SVH
`define SEGMENT_INTERSECTION_TEST_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SIT_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sit: same-cycle check failed");
`define SIT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sit: next-cycle check failed");
`else
`define SIT_ASSERT_IMPL(label, ante, cons)
`define SIT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/sit_pkg.sv =====
// Package for the segment intersection test core: widths, payload and stage types.
// No dependencies; imported by the request channel interface and every pipeline stage.
package sit_pkg;

   localparam int COORD_BITS = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;

   // input register, difference, product and result stages
   localparam int STAGES     = 4;

   // pairs that need both cross and dot product (endpoint on segment)
   localparam int CD_PAIRS   = 4;
   localparam int CD_SA_ON_T = 0;
   localparam int CD_SB_ON_T = 1;
   localparam int CD_TA_ON_S = 2;
   localparam int CD_TB_ON_S = 3;

   // pairs that need the cross product only
   localparam int CR_PAIRS    = 5;
   localparam int CR_PARALLEL = 0;
   localparam int CR_DS_U1    = 1;
   localparam int CR_DS_U2    = 2;
   localparam int CR_DT_U1    = 3;
   localparam int CR_DT_U3    = 4;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [SUM_BITS-1:0]   sum_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      point_type sa;
      point_type sb;
      point_type ta;
      point_type tb;
   } segs_type;

   typedef struct packed {
      diff_type x;
      diff_type y;
   } vec_type;

   // u1 = sa-ta, u2 = sa-tb, u3 = sb-ta, u4 = sb-tb, ds = sb-sa, dt = tb-ta
   typedef struct packed {
      vec_type u1;
      vec_type u2;
      vec_type u3;
      vec_type u4;
      vec_type ds;
      vec_type dt;
   } deltas_type;

   typedef struct packed {
      prod_type xy;
      prod_type yx;
      prod_type xx;
      prod_type yy;
   } cd_prod_type;

   typedef struct packed {
      prod_type xy;
      prod_type yx;
   } cr_prod_type;

   typedef struct packed {
      cd_prod_type [CD_PAIRS-1:0] cd;
      cr_prod_type [CR_PAIRS-1:0] cr;
      logic                       eq_any;
      logic                       bbox_reject;
   } prods_type;

endpackage

// ===== design/sit_req_if.sv =====
// Request channel: one segment pair per transaction, valid/ready handshake.
// Depends on sit_pkg for the coordinate type.
interface sit_req_if;
   import sit_pkg::*;

   logic      valid;
   logic      ready;
   coord_type s_start_x;
   coord_type s_start_y;
   coord_type s_end_x;
   coord_type s_end_y;
   coord_type t_start_x;
   coord_type t_start_y;
   coord_type t_end_x;
   coord_type t_end_y;

   modport source (
      output valid, s_start_x, s_start_y, s_end_x, s_end_y,
      output t_start_x, t_start_y, t_end_x, t_end_y,
      input  ready
   );
   modport sink (
      input  valid, s_start_x, s_start_y, s_end_x, s_end_y,
      input  t_start_x, t_start_y, t_end_x, t_end_y,
      output ready
   );
endinterface

// ===== design/sit_rsp_if.sv =====
// Response channel: one intersection flag per transaction, valid/ready handshake.
// Stand-alone; no package types needed.
interface sit_rsp_if;
   logic valid;
   logic ready;
   logic intersects;

   modport source (
      output valid, intersects,
      input  ready
   );
   modport sink (
      input  valid, intersects,
      output ready
   );
endinterface

// ===== design/sit_delta.sv =====
// Difference stage: forms the endpoint difference vectors of a segment pair.
// Depends on sit_pkg.
module sit_delta (
   input  logic                clock,
   input  logic                advance,
   input  sit_pkg::segs_type   segs,
   output sit_pkg::deltas_type deltas_ff
);
   import sit_pkg::*;

   deltas_type deltas_in;

   function automatic vec_type vsub(input point_type a, input point_type b);
      vec_type r;
      r.x = diff_type'(a.x) - diff_type'(b.x);
      r.y = diff_type'(a.y) - diff_type'(b.y);
      return r;
   endfunction

   always_comb begin
      deltas_in.u1 = vsub(segs.sa, segs.ta);
      deltas_in.u2 = vsub(segs.sa, segs.tb);
      deltas_in.u3 = vsub(segs.sb, segs.ta);
      deltas_in.u4 = vsub(segs.sb, segs.tb);
      deltas_in.ds = vsub(segs.sb, segs.sa);
      deltas_in.dt = vsub(segs.tb, segs.ta);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         deltas_ff <= deltas_in;
      end
   end
endmodule

// ===== design/sit_product.sv =====
// Product stage: all partial products of the cross and dot tests, plus the
// shared-endpoint and bounding-box flags. Depends on sit_pkg.
module sit_product (
   input  logic                clock,
   input  logic                advance,
   input  sit_pkg::deltas_type deltas,
   output sit_pkg::prods_type  prods_ff
);
   import sit_pkg::*;

   prods_type prods_in;
   logic      x_pos;
   logic      x_neg;
   logic      y_pos;
   logic      y_neg;

   function automatic prod_type mul(input diff_type a, input diff_type b);
      prod_type r;
      r = prod_type'(a) * prod_type'(b);
      return r;
   endfunction

   function automatic cd_prod_type cd_mul(input vec_type a, input vec_type b);
      cd_prod_type r;
      r.xy = mul(a.x, b.y);
      r.yx = mul(a.y, b.x);
      r.xx = mul(a.x, b.x);
      r.yy = mul(a.y, b.y);
      return r;
   endfunction

   function automatic cr_prod_type cr_mul(input vec_type a, input vec_type b);
      cr_prod_type r;
      r.xy = mul(a.x, b.y);
      r.yx = mul(a.y, b.x);
      return r;
   endfunction

   function automatic logic is_pos(input diff_type d);
      return !d[DIFF_BITS-1] && (d != '0);
   endfunction

   function automatic logic is_zero(input vec_type v);
      return (v.x == '0) && (v.y == '0);
   endfunction

   always_comb begin
      prods_in.cd[CD_SA_ON_T] = cd_mul(deltas.u1, deltas.u2);
      prods_in.cd[CD_SB_ON_T] = cd_mul(deltas.u3, deltas.u4);
      prods_in.cd[CD_TA_ON_S] = cd_mul(deltas.u1, deltas.u3);
      prods_in.cd[CD_TB_ON_S] = cd_mul(deltas.u2, deltas.u4);

      prods_in.cr[CR_PARALLEL] = cr_mul(deltas.ds, deltas.dt);
      prods_in.cr[CR_DS_U1]    = cr_mul(deltas.ds, deltas.u1);
      prods_in.cr[CR_DS_U2]    = cr_mul(deltas.ds, deltas.u2);
      prods_in.cr[CR_DT_U1]    = cr_mul(deltas.dt, deltas.u1);
      prods_in.cr[CR_DT_U3]    = cr_mul(deltas.dt, deltas.u3);

      prods_in.eq_any = is_zero(deltas.u1) || is_zero(deltas.u2) ||
                        is_zero(deltas.u3) || is_zero(deltas.u4);

      // boxes are disjoint when every S coordinate lies strictly on one side of every T one
      x_pos = is_pos(deltas.u1.x) && is_pos(deltas.u2.x) &&
              is_pos(deltas.u3.x) && is_pos(deltas.u4.x);
      x_neg = deltas.u1.x[DIFF_BITS-1] && deltas.u2.x[DIFF_BITS-1] &&
              deltas.u3.x[DIFF_BITS-1] && deltas.u4.x[DIFF_BITS-1];
      y_pos = is_pos(deltas.u1.y) && is_pos(deltas.u2.y) &&
              is_pos(deltas.u3.y) && is_pos(deltas.u4.y);
      y_neg = deltas.u1.y[DIFF_BITS-1] && deltas.u2.y[DIFF_BITS-1] &&
              deltas.u3.y[DIFF_BITS-1] && deltas.u4.y[DIFF_BITS-1];
      prods_in.bbox_reject = x_pos || x_neg || y_pos || y_neg;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prods_ff <= prods_in;
      end
   end
endmodule

// ===== design/sit_decide.sv =====
// Decision stage: finishes cross and dot products and registers the verdict.
// Depends on sit_pkg and the assertion macro header.
`include "segment_intersection_test_core_macros.svh"
module sit_decide (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  sit_pkg::prods_type prods,
   output logic               intersects_ff
);
   import sit_pkg::*;

   logic                intersects_in;
   logic [CD_PAIRS-1:0] on_seg;
   sum_type             cr_val [CR_PAIRS];
   sum_type             cd_cross;
   sum_type             cd_dot;
   logic                parallel;
   logic                side_s;
   logic                side_t;
   logic                lies_any;

   function automatic logic is_pos(input sum_type v);
      return !v[SUM_BITS-1] && (v != '0);
   endfunction

   always_comb begin
      for (int k = 0; k < CD_PAIRS; k++) begin
         cd_cross = sum_type'(prods.cd[k].xy) - sum_type'(prods.cd[k].yx);
         cd_dot   = sum_type'(prods.cd[k].xx) + sum_type'(prods.cd[k].yy);
         on_seg[k] = (cd_cross == '0) && !is_pos(cd_dot);
      end
      for (int k = 0; k < CR_PAIRS; k++) begin
         cr_val[k] = sum_type'(prods.cr[k].xy) - sum_type'(prods.cr[k].yx);
      end
      lies_any = |on_seg;
      parallel = (cr_val[CR_PARALLEL] == '0);
      side_s   = cr_val[CR_DS_U1][SUM_BITS-1] == is_pos(cr_val[CR_DS_U2]);
      side_t   = is_pos(cr_val[CR_DT_U1]) == cr_val[CR_DT_U3][SUM_BITS-1];
      intersects_in = prods.eq_any ||
                      (!prods.bbox_reject && (lies_any || (!parallel && side_s && side_t)));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         intersects_ff <= intersects_in;
      end
   end

   `SIT_ASSERT_NEXT(a_shared_end_hits, advance && prods.eq_any, intersects_ff)
   `SIT_ASSERT_NEXT(a_box_miss, advance && prods.bbox_reject && !prods.eq_any, !intersects_ff)
   `SIT_ASSERT_NEXT(a_hold_on_stall, !advance, $stable(intersects_ff))
endmodule

// ===== design/segment_intersection_test_core.sv =====
// Segment intersection test core: four-stage pipeline, one pair per cycle without backpressure.
// A request passes the input, difference, product and result registers in that order.
// Throughput: one transaction per cycle unless the response side stalls; each stage holds
// one transaction and moves it on whenever the next stage is empty or moving too.
// Backpressure stalls only full stages, so bubbles are squeezed out.
// Reset (synchronous) clears the stage valid flags; payload registers are not cleared.
`include "segment_intersection_test_core_macros.svh"
module segment_intersection_test_core (
   input  logic      clock,
   input  logic      reset,
   sit_req_if.sink   req_bus,
   sit_rsp_if.source rsp_bus
);
   import sit_pkg::*;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] advance;
   segs_type          segs_ff;
   segs_type          segs_in;
   deltas_type        deltas;
   prods_type         prods;
   logic              intersects;

   always_comb begin
      advance[STAGES-1] = !valid_ff[STAGES-1] || rsp_bus.ready;
      for (int k = STAGES-2; k >= 0; k--) begin
         advance[k] = !valid_ff[k] || advance[k+1];
      end
      valid_in[0] = advance[0] ? req_bus.valid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = advance[k] ? valid_ff[k-1] : valid_ff[k];
      end
      segs_in.sa.x = req_bus.s_start_x;
      segs_in.sa.y = req_bus.s_start_y;
      segs_in.sb.x = req_bus.s_end_x;
      segs_in.sb.y = req_bus.s_end_y;
      segs_in.ta.x = req_bus.t_start_x;
      segs_in.ta.y = req_bus.t_start_y;
      segs_in.tb.x = req_bus.t_end_x;
      segs_in.tb.y = req_bus.t_end_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      if (advance[0]) begin
         segs_ff <= segs_in;
      end
   end

   sit_delta u_delta (
      .clock     (clock),
      .advance   (advance[1]),
      .segs      (segs_ff),
      .deltas_ff (deltas)
   );

   sit_product u_product (
      .clock    (clock),
      .advance  (advance[2]),
      .deltas   (deltas),
      .prods_ff (prods)
   );

   sit_decide u_decide (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance[3]),
      .prods         (prods),
      .intersects_ff (intersects)
   );

   assign req_bus.ready      = advance[0];
   assign rsp_bus.valid      = valid_ff[STAGES-1];
   assign rsp_bus.intersects = intersects;

   `SIT_ASSERT_IMPL(a_stall_only_full, !req_bus.ready, (valid_ff == '1) && !rsp_bus.ready)
   `SIT_ASSERT_NEXT(a_accept_lands, req_bus.valid && req_bus.ready, valid_ff[0])
   `SIT_ASSERT_NEXT(a_tail_moves, valid_ff[2] && advance[3], valid_ff[3])
endmodule
